>>> hdl/ray_dda_setup_assert.svh
// ------------------------------------------------------------------------
// Assertion macros for the ray setup block
// Concurrent checks that vanish when SYNTHESIS is defined.
// ------------------------------------------------------------------------
`ifndef RAY_DDA_SETUP_ASSERT_SVH
`define RAY_DDA_SETUP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define RDS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define RDS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RDS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define RDS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

>>> hdl/rds_pkg.sv
// ------------------------------------------------------------------------
// rds_pkg
// Widths, constants and item types shared by the ray setup modules.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

package rds_pkg;

   localparam int MAP_BITS  = 8;
   localparam int FRAC_BITS = 16;

   localparam int ANG_W = FRAC_BITS + 4;
   localparam int POS_W = MAP_BITS + FRAC_BITS;
   localparam int DIR_W = FRAC_BITS + 2;
   localparam int MAG_W = FRAC_BITS + 1;
   localparam int NUM_W = 2 * FRAC_BITS + 1;
   localparam int QX_W  = (NUM_W > 33) ? NUM_W : 33;

   // Rotation arithmetic is Q4.30 whatever the output precision.
   localparam int INT_BITS = 30;
   localparam int ITERS    = 30;
   localparam int CW       = 34;
   localparam int RW       = 36;
   localparam int Q_SHIFT  = INT_BITS - FRAC_BITS;

   localparam logic signed [RW-1:0] PI_Q30      = 36'sd3373259426;
   localparam logic signed [RW-1:0] HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [RW-1:0] TWO_PI_Q30  = 36'sd6746518852;
   localparam logic signed [CW-1:0] GAIN_Q30    = 34'sd652032874;

   localparam int ONE_INT = 1 << FRAC_BITS;
   localparam logic signed [DIR_W-1:0] ONE_DIR = DIR_W'(ONE_INT);
   localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

   // Queue depths must be powers of two so the pointers wrap by themselves.
   localparam int MQ_DEPTH = 4;
   localparam int MQ_PTR_W = $clog2(MQ_DEPTH);
   localparam int OQ_DEPTH = 2;
   localparam int OQ_PTR_W = $clog2(OQ_DEPTH);

   typedef struct packed {
      logic signed [DIR_W-1:0] dir_x;
      logic signed [DIR_W-1:0] dir_y;
      logic [POS_W-1:0]        pos_x;
      logic [POS_W-1:0]        pos_y;
   } rds_mid_type;

   typedef struct packed {
      logic signed [DIR_W-1:0] dir_x;
      logic signed [DIR_W-1:0] dir_y;
      logic [31:0]             delta_x;
      logic [31:0]             delta_y;
      logic [MAP_BITS-1:0]     cell_x;
      logic [MAP_BITS-1:0]     cell_y;
      logic                    x_steps_back;
      logic                    y_steps_back;
      logic [31:0]             side_x;
      logic [31:0]             side_y;
   } rds_rsp_type;

endpackage

>>> hdl/rds_front.sv
// ------------------------------------------------------------------------
// rds_front
// Angle folding and a pipelined rotation-mode CORDIC giving the direction.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module rds_front import rds_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic signed [ANG_W-1:0] heading,
   input  logic [POS_W-1:0]        pos_x,
   input  logic [POS_W-1:0]        pos_y,
   output logic                    out_valid,
   output rds_mid_type             out_data
);

   localparam logic signed [CW-1:0] ONE_CW   = CW'(ONE_INT);
   localparam logic signed [CW-1:0] ROUND_CW = CW'(1 << (Q_SHIFT - 1));

   function automatic logic signed [CW-1:0] atan_q30(input int i);
      logic [31:0] v;
      unique case (i)
         0:  v = 32'h3243F6A8;  1: v = 32'h1DAC6705;  2: v = 32'h0FADBAFC;
         3:  v = 32'h07F56EA6;  4: v = 32'h03FEAB76;  5: v = 32'h01FFD55B;
         6:  v = 32'h00FFFAAA;  7: v = 32'h007FFF55;  8: v = 32'h003FFFEA;
         9:  v = 32'h001FFFFD; 10: v = 32'h000FFFFF; 11: v = 32'h0007FFFF;
         12: v = 32'h0003FFFF; 13: v = 32'h0001FFFF; 14: v = 32'h0000FFFF;
         15: v = 32'h00007FFF; 16: v = 32'h00003FFF; 17: v = 32'h00001FFF;
         18: v = 32'h00000FFF; 19: v = 32'h000007FF; 20: v = 32'h000003FF;
         21: v = 32'h000001FF; 22: v = 32'h000000FF; 23: v = 32'h0000007F;
         24: v = 32'h0000003F; 25: v = 32'h0000001F; 26: v = 32'h0000000F;
         27: v = 32'h00000007; 28: v = 32'h00000003; 29: v = 32'h00000001;
         default: v = 32'h0;
      endcase
      return CW'(v);
   endfunction

   // Round half up to the output precision and clamp to plus or minus one.
   function automatic logic signed [DIR_W-1:0] to_dir(input logic signed [CW-1:0] v);
      logic signed [CW-1:0] r;
      r = (v + ROUND_CW) >>> Q_SHIFT;
      if (r > ONE_CW) r = ONE_CW;
      if (r < -ONE_CW) r = -ONE_CW;
      return DIR_W'(r);
   endfunction

   logic signed [RW-1:0] a_ext;
   logic signed [RW-1:0] a_fold;

   logic                 r0_valid_ff;
   logic signed [RW-1:0] r0_a_ff;
   logic [POS_W-1:0]     r0_px_ff, r0_py_ff;

   logic                 st_valid_ff [0:ITERS];
   logic                 st_neg_ff   [0:ITERS];
   logic signed [CW-1:0] st_x_ff     [0:ITERS];
   logic signed [CW-1:0] st_y_ff     [0:ITERS];
   logic signed [CW-1:0] st_z_ff     [0:ITERS];
   logic [POS_W-1:0]     st_px_ff    [0:ITERS];
   logic [POS_W-1:0]     st_py_ff    [0:ITERS];

   logic signed [CW-1:0] x_in [0:ITERS-1];
   logic signed [CW-1:0] y_in [0:ITERS-1];
   logic signed [CW-1:0] z_in [0:ITERS-1];

   logic signed [RW-1:0] r1_a_in;
   logic                 r1_neg_in;

   logic                 n_valid_ff;
   logic signed [CW-1:0] n_x_ff, n_y_ff;
   logic [POS_W-1:0]     n_px_ff, n_py_ff;

   logic                 d_valid_ff;
   rds_mid_type          d_ff;

   assign a_ext = RW'(heading) <<< Q_SHIFT;

   always_comb begin
      if (a_ext > PI_Q30) begin
         a_fold = a_ext - TWO_PI_Q30;
      end else if (a_ext < -PI_Q30) begin
         a_fold = a_ext + TWO_PI_Q30;
      end else begin
         a_fold = a_ext;
      end
   end

   // Fold into the right half plane; the flip is undone after rotation.
   always_comb begin
      r1_neg_in = 1'b1;
      if (r0_a_ff > HALF_PI_Q30) begin
         r1_a_in = r0_a_ff - PI_Q30;
      end else if (r0_a_ff < -HALF_PI_Q30) begin
         r1_a_in = r0_a_ff + PI_Q30;
      end else begin
         r1_a_in   = r0_a_ff;
         r1_neg_in = 1'b0;
      end
   end

   always_comb begin
      for (int i = 0; i < ITERS; i++) begin
         if (st_z_ff[i] >= 0) begin
            x_in[i] = st_x_ff[i] - (st_y_ff[i] >>> i);
            y_in[i] = st_y_ff[i] + (st_x_ff[i] >>> i);
            z_in[i] = st_z_ff[i] - atan_q30(i);
         end else begin
            x_in[i] = st_x_ff[i] + (st_y_ff[i] >>> i);
            y_in[i] = st_y_ff[i] - (st_x_ff[i] >>> i);
            z_in[i] = st_z_ff[i] + atan_q30(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r0_valid_ff <= 1'b0;
         for (int i = 0; i <= ITERS; i++) st_valid_ff[i] <= 1'b0;
         n_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else if (en) begin
         r0_valid_ff    <= in_valid;
         st_valid_ff[0] <= r0_valid_ff;
         for (int i = 0; i < ITERS; i++) st_valid_ff[i+1] <= st_valid_ff[i];
         n_valid_ff <= st_valid_ff[ITERS];
         d_valid_ff <= n_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r0_a_ff  <= a_fold;
         r0_px_ff <= pos_x;
         r0_py_ff <= pos_y;

         st_neg_ff[0] <= r1_neg_in;
         st_x_ff[0]   <= GAIN_Q30;
         st_y_ff[0]   <= '0;
         st_z_ff[0]   <= CW'(r1_a_in);
         st_px_ff[0]  <= r0_px_ff;
         st_py_ff[0]  <= r0_py_ff;
         for (int i = 0; i < ITERS; i++) begin
            st_neg_ff[i+1] <= st_neg_ff[i];
            st_x_ff[i+1]   <= x_in[i];
            st_y_ff[i+1]   <= y_in[i];
            st_z_ff[i+1]   <= z_in[i];
            st_px_ff[i+1]  <= st_px_ff[i];
            st_py_ff[i+1]  <= st_py_ff[i];
         end

         n_x_ff  <= st_neg_ff[ITERS] ? -st_x_ff[ITERS] : st_x_ff[ITERS];
         n_y_ff  <= st_neg_ff[ITERS] ? -st_y_ff[ITERS] : st_y_ff[ITERS];
         n_px_ff <= st_px_ff[ITERS];
         n_py_ff <= st_py_ff[ITERS];

         d_ff.dir_x <= to_dir(n_x_ff);
         d_ff.dir_y <= to_dir(n_y_ff);
         d_ff.pos_x <= n_px_ff;
         d_ff.pos_y <= n_py_ff;
      end
   end

   assign out_valid = d_valid_ff;
   assign out_data  = d_ff;

endmodule

>>> hdl/rds_mid_queue.sv
// ------------------------------------------------------------------------
// rds_mid_queue
// Small register queue between the direction front and the divider back.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module rds_mid_queue import rds_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  rds_mid_type push_data,
   output logic        full,
   input  logic        pop,
   output rds_mid_type pop_data,
   output logic        empty
);

   rds_mid_type         mem_ff [0:MQ_DEPTH-1];
   logic [MQ_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [MQ_PTR_W:0]   count_ff;
   logic                do_push, do_pop;

   assign full     = count_ff == (MQ_PTR_W+1)'(MQ_DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

>>> hdl/rds_divider.sv
// ------------------------------------------------------------------------
// rds_divider
// Pipelined restoring divider, one quotient bit per stage.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module rds_divider import rds_pkg::*; (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num_in,
   input  logic [MAG_W-1:0] den_in,
   output logic [NUM_W-1:0] quo
);

   logic [MAG_W-1:0] rem_ff [0:NUM_W];
   logic [NUM_W-1:0] num_ff [0:NUM_W];
   logic [MAG_W-1:0] den_ff [0:NUM_W];
   logic [NUM_W-1:0] quo_ff [0:NUM_W];

   logic [MAG_W:0]   trial [0:NUM_W-1];
   logic             ge    [0:NUM_W-1];
   logic [MAG_W-1:0] rem_in [0:NUM_W-1];

   always_comb begin
      for (int k = 0; k < NUM_W; k++) begin
         trial[k] = {rem_ff[k], num_ff[k][NUM_W-1]};
         ge[k]    = trial[k] >= {1'b0, den_ff[k]};
         if (ge[k]) begin
            rem_in[k] = MAG_W'(trial[k] - {1'b0, den_ff[k]});
         end else begin
            rem_in[k] = MAG_W'(trial[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= '0;
         num_ff[0] <= num_in;
         den_ff[0] <= den_in;
         quo_ff[0] <= '0;
         for (int k = 0; k < NUM_W; k++) begin
            rem_ff[k+1] <= rem_in[k];
            num_ff[k+1] <= num_ff[k] << 1;
            den_ff[k+1] <= den_ff[k];
            quo_ff[k+1] <= {quo_ff[k][NUM_W-2:0], ge[k]};
         end
      end
   end

   assign quo = quo_ff[NUM_W];

endmodule

>>> hdl/rds_back.sv
// ------------------------------------------------------------------------
// rds_back
// Per-axis step setup, four pipelined dividers and the result queue.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module rds_back import rds_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        mid_empty,
   input  rds_mid_type mid_data,
   output logic        mid_pop,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rds_rsp_type rsp_data
);

   typedef struct packed {
      logic signed [DIR_W-1:0] dir_x;
      logic signed [DIR_W-1:0] dir_y;
      logic [MAP_BITS-1:0]     cell_x;
      logic [MAP_BITS-1:0]     cell_y;
      logic                    back_x;
      logic                    back_y;
      logic                    zero_x;
      logic                    zero_y;
   } rds_info_type;

   localparam logic [MAG_W-1:0] ONE_MAG   = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [NUM_W-1:0] NUM_DELTA = {1'b1, {(2*FRAC_BITS){1'b0}}};

   function automatic logic [31:0] sat_q(input logic zero, input logic [NUM_W-1:0] q);
      logic [QX_W-1:0] qx;
      qx = QX_W'(q);
      if (zero || (|qx[QX_W-1:32])) return SAT32;
      return qx[31:0];
   endfunction

   logic                en;
   logic                oq_full;
   logic                back_x, back_y;
   logic [MAG_W-1:0]    mag_x, mag_y, dist_x, dist_y;
   logic signed [DIR_W-1:0] neg_x, neg_y;
   rds_info_type        info_in;

   logic                info_valid_ff [0:NUM_W];
   rds_info_type        info_ff       [0:NUM_W];

   logic [NUM_W-1:0]    q_dx, q_dy, q_sx, q_sy;
   rds_rsp_type         result;
   logic                oq_push, oq_pop;

   rds_rsp_type         oq_ff [0:OQ_DEPTH-1];
   logic [OQ_PTR_W-1:0] oq_wr_ff, oq_rd_ff;
   logic [OQ_PTR_W:0]   oq_count_ff;

   assign oq_full = oq_count_ff == (OQ_PTR_W+1)'(OQ_DEPTH);
   assign en      = !oq_full;
   assign mid_pop = en && !mid_empty;

   assign back_x = mid_data.dir_x[DIR_W-1];
   assign back_y = mid_data.dir_y[DIR_W-1];
   assign neg_x  = -mid_data.dir_x;
   assign neg_y  = -mid_data.dir_y;
   assign mag_x  = back_x ? MAG_W'(neg_x) : MAG_W'(mid_data.dir_x);
   assign mag_y  = back_y ? MAG_W'(neg_y) : MAG_W'(mid_data.dir_y);

   // Backwards the distance is the fraction itself, forwards its complement.
   assign dist_x = back_x ? {1'b0, mid_data.pos_x[FRAC_BITS-1:0]}
                          : ONE_MAG - {1'b0, mid_data.pos_x[FRAC_BITS-1:0]};
   assign dist_y = back_y ? {1'b0, mid_data.pos_y[FRAC_BITS-1:0]}
                          : ONE_MAG - {1'b0, mid_data.pos_y[FRAC_BITS-1:0]};

   always_comb begin
      info_in.dir_x  = mid_data.dir_x;
      info_in.dir_y  = mid_data.dir_y;
      info_in.cell_x = mid_data.pos_x[POS_W-1:FRAC_BITS];
      info_in.cell_y = mid_data.pos_y[POS_W-1:FRAC_BITS];
      info_in.back_x = back_x;
      info_in.back_y = back_y;
      info_in.zero_x = mag_x == '0;
      info_in.zero_y = mag_y == '0;
   end

   rds_divider u_div_dx (.clock(clock), .en(en), .num_in(NUM_DELTA), .den_in(mag_x),
                         .quo(q_dx));
   rds_divider u_div_dy (.clock(clock), .en(en), .num_in(NUM_DELTA), .den_in(mag_y),
                         .quo(q_dy));
   rds_divider u_div_sx (.clock(clock), .en(en), .num_in({dist_x, {FRAC_BITS{1'b0}}}),
                         .den_in(mag_x), .quo(q_sx));
   rds_divider u_div_sy (.clock(clock), .en(en), .num_in({dist_y, {FRAC_BITS{1'b0}}}),
                         .den_in(mag_y), .quo(q_sy));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= NUM_W; k++) info_valid_ff[k] <= 1'b0;
      end else if (en) begin
         info_valid_ff[0] <= mid_pop;
         for (int k = 0; k < NUM_W; k++) info_valid_ff[k+1] <= info_valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         info_ff[0] <= info_in;
         for (int k = 0; k < NUM_W; k++) info_ff[k+1] <= info_ff[k];
      end
   end

   always_comb begin
      result.dir_x        = info_ff[NUM_W].dir_x;
      result.dir_y        = info_ff[NUM_W].dir_y;
      result.delta_x      = sat_q(info_ff[NUM_W].zero_x, q_dx);
      result.delta_y      = sat_q(info_ff[NUM_W].zero_y, q_dy);
      result.cell_x       = info_ff[NUM_W].cell_x;
      result.cell_y       = info_ff[NUM_W].cell_y;
      result.x_steps_back = info_ff[NUM_W].back_x;
      result.y_steps_back = info_ff[NUM_W].back_y;
      result.side_x       = sat_q(info_ff[NUM_W].zero_x, q_sx);
      result.side_y       = sat_q(info_ff[NUM_W].zero_y, q_sy);
   end

   assign oq_push   = en && info_valid_ff[NUM_W];
   assign rsp_empty = oq_count_ff == '0;
   assign oq_pop    = rsp_pop && !rsp_empty;
   assign rsp_data  = oq_ff[oq_rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wr_ff    <= '0;
         oq_rd_ff    <= '0;
         oq_count_ff <= '0;
      end else begin
         if (oq_push) oq_wr_ff <= oq_wr_ff + 1'b1;
         if (oq_pop) oq_rd_ff <= oq_rd_ff + 1'b1;
         if (oq_push && !oq_pop) begin
            oq_count_ff <= oq_count_ff + 1'b1;
         end else if (oq_pop && !oq_push) begin
            oq_count_ff <= oq_count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (oq_push) oq_ff[oq_wr_ff] <= result;
   end

endmodule

>>> hdl/ray_dda_setup.sv
// ------------------------------------------------------------------------
// ray_dda_setup
// Per-ray setup for a grid-stepping raycaster: direction, grid spacing,
// starting cell, step signs and distances to the first grid lines.
// ------------------------------------------------------------------------
//
//   Channel   Handshake            Contents
//   req_      push / full          ray heading, player x and y
//   rsp_      empty / pop          direction, deltas, cells, step signs, sides
//
// One item is accepted every cycle while the middle queue is not full. An
// item passes 34 register stages in the front (two angle folding stages, 30
// CORDIC stages, negation and rounding), one in the middle queue and
// 2*FRAC_BITS+3 in the back, where the four dividers each settle one quotient
// bit per stage before the result queue is written; with the default FRAC_BITS
// that is 70 stages.
// Reset is synchronous and empties every stage and both queues.
// The front halts only while the middle queue is full and the back only while
// the result queue is full, so a stalled consumer backs up item by item.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ray_dda_setup_assert.svh"

module ray_dda_setup import rds_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  logic signed [ANG_W-1:0] req_heading,
   input  logic [POS_W-1:0]        req_pos_x,
   input  logic [POS_W-1:0]        req_pos_y,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output logic signed [DIR_W-1:0] rsp_dir_x,
   output logic signed [DIR_W-1:0] rsp_dir_y,
   output logic [31:0]             rsp_delta_x,
   output logic [31:0]             rsp_delta_y,
   output logic [MAP_BITS-1:0]     rsp_cell_x,
   output logic [MAP_BITS-1:0]     rsp_cell_y,
   output logic                    rsp_x_steps_back,
   output logic                    rsp_y_steps_back,
   output logic [31:0]             rsp_side_x,
   output logic [31:0]             rsp_side_y
);

   // The front moves as one whole while the middle queue has room. The queue
   // is never full when the back keeps draining it, so nothing is lost.
   logic        mid_full;
   logic        mid_empty;
   logic        mid_pop;
   logic        front_valid;
   rds_mid_type front_data;
   rds_mid_type mid_data;
   rds_rsp_type rsp_data;

   assign req_full = mid_full;

   rds_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (!mid_full),
      .in_valid  (req_push),
      .heading   (req_heading),
      .pos_x     (req_pos_x),
      .pos_y     (req_pos_y),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   rds_mid_queue u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid && !mid_full),
      .push_data (front_data),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_data),
      .empty     (mid_empty)
   );

   // The back pulls from the middle queue whenever its result queue has room;
   // a zero direction component is carried as a flag and saturates there.
   rds_back u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .mid_data  (mid_data),
      .mid_pop   (mid_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   assign rsp_dir_x        = rsp_data.dir_x;
   assign rsp_dir_y        = rsp_data.dir_y;
   assign rsp_delta_x      = rsp_data.delta_x;
   assign rsp_delta_y      = rsp_data.delta_y;
   assign rsp_cell_x       = rsp_data.cell_x;
   assign rsp_cell_y       = rsp_data.cell_y;
   assign rsp_x_steps_back = rsp_data.x_steps_back;
   assign rsp_y_steps_back = rsp_data.y_steps_back;
   assign rsp_side_x       = rsp_data.side_x;
   assign rsp_side_y       = rsp_data.side_y;

   // A waiting item's step signs follow the signs of its direction.
   `RDS_ASSERT_IMP(a_step_sign, clock, reset, !rsp_empty, (rsp_x_steps_back == rsp_dir_x[DIR_W-1]) && (rsp_y_steps_back == rsp_dir_y[DIR_W-1]), "step sign disagrees with direction")
   // A zero x component saturates both x distances and steps forward.
   `RDS_ASSERT_IMP(a_zero_x, clock, reset, !rsp_empty && (rsp_dir_x == '0), (rsp_delta_x == SAT32) && (rsp_side_x == SAT32) && !rsp_x_steps_back, "zero x direction not saturated")
   // The rounded direction never leaves the unit range.
   `RDS_ASSERT_IMP(a_dir_range, clock, reset, !rsp_empty, (rsp_dir_x <= ONE_DIR) && (rsp_dir_x >= -ONE_DIR) && (rsp_dir_y <= ONE_DIR) && (rsp_dir_y >= -ONE_DIR), "direction out of range")

endmodule
